### hdl/lspb_pkg.sv
`timescale 1ns / 1ps
// Types, command codes and helpers shared by the LED slot pattern blinker.
// No dependencies; every other file imports this package.
package lspb_pkg;

    localparam int PIN_W     = 4;
    localparam int MASK_W    = 16;
    localparam int REP_W     = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;
    localparam int SLOT_MAX_W = 5;

    localparam logic [2:0] CMD_TICK      = 3'd0;
    localparam logic [2:0] CMD_OFF       = 3'd1;
    localparam logic [2:0] CMD_ON        = 3'd2;
    localparam logic [2:0] CMD_BLINK_DEF = 3'd3;
    localparam logic [2:0] CMD_BLINK     = 3'd4;
    localparam logic [2:0] CMD_TOGGLE    = 3'd5;
    localparam logic [2:0] CMD_READ      = 3'd6;

    localparam logic [1:0] MODE_OFF   = 2'd0;
    localparam logic [1:0] MODE_ON    = 2'd1;
    localparam logic [1:0] MODE_BLINK = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_PRESENT     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_MASK = 2'd2;

    typedef struct packed {
        logic [2:0]        cmd;
        logic [1:0]        led_index;
        logic [MASK_W-1:0] on_mask;
        logic [REP_W-1:0]  repeat_count;
    } cmd_word_t;

    typedef struct packed {
        logic [PIN_W-1:0] pin_levels;
        logic [1:0]       led_mode_out;
        logic             status;
        logic             timer_running;
    } res_word_t;

    // one LED's stored record
    typedef struct packed {
        logic [1:0]        mode;
        logic [MASK_W-1:0] mask;
        logic              rep_forever;
        logic [REP_W-1:0]  repeats;
    } led_rec_t;

    typedef struct packed {
        logic [PIN_W-1:0]  present;
        logic [PIN_W-1:0]  active_high;
        logic [MASK_W-1:0] default_mask;
    } cfg_t;

    // slots from sixteen up read as unlit
    function automatic logic mask_bit(logic [MASK_W-1:0] m, logic [SLOT_MAX_W-1:0] s);
        return (s < SLOT_MAX_W'(MASK_W)) ? m[s[3:0]] : 1'b0;
    endfunction

endpackage

### hdl/lspb_led_ram.sv
`timescale 1ns / 1ps
// LED record memory: one write port, one registered read port, write-first bypass.
// Entries never written read as the all-off record. Uses lspb_pkg.
module lspb_led_ram #(
    parameter int LED_COUNT = 4,
    parameter int AW = 2
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  logic [AW-1:0]      wr_addr,
    input  lspb_pkg::led_rec_t wr_data,
    input  logic               rd_en,
    input  logic [AW-1:0]      rd_addr,
    output lspb_pkg::led_rec_t rd_data
);
    import lspb_pkg::*;

    led_rec_t             mem [LED_COUNT];
    logic [LED_COUNT-1:0] written_reg;
    led_rec_t             rd_data_reg;
    logic                 rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= (wr_en && wr_addr == rd_addr) ? wr_data : mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg <= '0;
            rd_vld_reg  <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                written_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_vld_reg <= written_reg[rd_addr] || (wr_en && wr_addr == rd_addr);
            end
        end
    end

    assign rd_data = rd_vld_reg ? rd_data_reg : '0;

endmodule

### hdl/lspb_seq.sv
`timescale 1ns / 1ps
// Command sequencer: reads an LED record, modifies it and writes it back; walks all
// records on a tick while the timer runs. Holds slot timer, blink flags, pin levels. Uses lspb_pkg.
module lspb_seq #(
    parameter int LED_COUNT = 4,
    parameter int SLOT_COUNT = 16,
    parameter int AW = 2
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  lspb_pkg::cmd_word_t in_data,
    input  lspb_pkg::cfg_t      cfg,
    output logic                res_valid,
    input  logic                res_ready,
    output lspb_pkg::res_word_t res_data,
    output logic                wr_en,
    output logic [AW-1:0]       wr_addr,
    output lspb_pkg::led_rec_t  wr_data,
    output logic                rd_en,
    output logic [AW-1:0]       rd_addr,
    input  lspb_pkg::led_rec_t  rd_data
);
    import lspb_pkg::*;

    localparam int SW = $clog2(SLOT_COUNT);
    localparam int CW = $clog2(LED_COUNT + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MOD  = 2'd1;
    localparam logic [1:0] ST_TICK = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]           state_reg, state_next;
    cmd_word_t            cmd_reg, cmd_next;
    logic                 timer_reg, timer_next;
    logic [SW-1:0]        slot_reg, slot_next;
    logic [SW-1:0]        prev_slot_reg, prev_slot_next;
    logic [LED_COUNT-1:0] blink_reg, blink_next;
    logic [PIN_W-1:0]     pins_reg, pins_next;
    logic [CW-1:0]        iss_reg, iss_next;
    logic                 proc_vld_reg, proc_vld_next;
    logic [AW-1:0]        proc_idx_reg, proc_idx_next;
    logic [1:0]           res_mode_reg, res_mode_next;
    logic                 res_status_reg, res_status_next;

    // command path helpers
    logic [AW-1:0]        cmd_addr;
    logic [1:0]           cmd_pin;
    logic                 cmd_present;
    logic                 cmd_is_set;
    led_rec_t             tgt_rec;
    logic                 set_write;
    logic [LED_COUNT-1:0] blink_after;
    logic                 any_blink;
    logic                 timer_start;
    logic [SW-1:0]        slot_eff;
    logic                 set_lit;

    // tick path helpers
    logic [1:0]           tick_pin;
    logic                 tick_pin_ok;
    logic                 tick_act;
    led_rec_t             tick_rec;
    logic                 issuing;

    assign cmd_addr    = AW'(cmd_reg.led_index);
    assign cmd_pin     = cmd_reg.led_index;
    assign cmd_present = cfg.present[cmd_pin];
    assign cmd_is_set  = (cmd_reg.cmd == CMD_OFF) || (cmd_reg.cmd == CMD_ON) ||
                         (cmd_reg.cmd == CMD_BLINK_DEF) || (cmd_reg.cmd == CMD_BLINK) ||
                         (cmd_reg.cmd == CMD_TOGGLE);

    always_comb
    begin
        tgt_rec = '0;
        case (cmd_reg.cmd)
            CMD_ON:
            begin
                tgt_rec.mode = MODE_ON;
            end
            CMD_BLINK_DEF:
            begin
                tgt_rec.mode        = MODE_BLINK;
                tgt_rec.mask        = cfg.default_mask;
                tgt_rec.rep_forever = 1'b1;
            end
            CMD_BLINK:
            begin
                tgt_rec.mode        = MODE_BLINK;
                tgt_rec.mask        = cmd_reg.on_mask;
                tgt_rec.rep_forever = (cmd_reg.repeat_count == '0);
                tgt_rec.repeats     = cmd_reg.repeat_count;
            end
            CMD_TOGGLE:
            begin
                tgt_rec.mode = (rd_data.mode == MODE_OFF) ? MODE_ON : MODE_OFF;
            end
            default:
            begin
                tgt_rec.mode = MODE_OFF;
            end
        endcase
    end

    assign set_write = cmd_present && cmd_is_set && (tgt_rec != rd_data);

    always_comb
    begin
        blink_after = blink_reg;
        blink_after[cmd_addr] = (tgt_rec.mode == MODE_BLINK);
    end

    assign any_blink   = |blink_after;
    assign timer_start = any_blink && !timer_reg;
    assign slot_eff    = timer_start ? '0 : slot_reg;
    assign set_lit     = (tgt_rec.mode == MODE_BLINK) ?
                         mask_bit(tgt_rec.mask, SLOT_MAX_W'(slot_eff)) :
                         (tgt_rec.mode == MODE_ON);

    assign tick_pin    = 2'(proc_idx_reg);
    assign tick_pin_ok = (32'(proc_idx_reg) < PIN_W);
    assign tick_act    = (rd_data.mode == MODE_BLINK) && (rd_data.mask != '0) &&
                         (rd_data.rep_forever || rd_data.repeats != '0);
    assign issuing     = (iss_reg != CW'(LED_COUNT));

    always_comb
    begin
        tick_rec = rd_data;
        if (!rd_data.rep_forever)
        begin
            tick_rec.repeats = rd_data.repeats - 1'b1;
            if (tick_rec.repeats == '0)
            begin
                tick_rec.mode = MODE_OFF;
                tick_rec.mask = '0;
            end
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        timer_next      = timer_reg;
        slot_next       = slot_reg;
        prev_slot_next  = prev_slot_reg;
        blink_next      = blink_reg;
        pins_next       = pins_reg;
        iss_next        = iss_reg;
        proc_vld_next   = proc_vld_reg;
        proc_idx_next   = proc_idx_reg;
        res_mode_next   = res_mode_reg;
        res_status_next = res_status_reg;
        rd_en   = 1'b0;
        rd_addr = '0;
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next        = in_data;
                    res_mode_next   = MODE_OFF;
                    res_status_next = 1'b0;
                    case (in_data.cmd)
                        CMD_TICK:
                        begin
                            if (timer_reg)
                            begin
                                prev_slot_next = slot_reg;
                                slot_next = (32'(slot_reg) + 1 >= SLOT_COUNT) ?
                                            '0 : slot_reg + 1'b1;
                                iss_next      = '0;
                                proc_vld_next = 1'b0;
                                state_next    = ST_TICK;
                            end
                            else
                            begin
                                state_next = ST_DONE;
                            end
                        end
                        CMD_OFF, CMD_ON, CMD_BLINK_DEF, CMD_BLINK, CMD_TOGGLE, CMD_READ:
                        begin
                            if (32'(in_data.led_index) < LED_COUNT)
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = AW'(in_data.led_index);
                                state_next = ST_MOD;
                            end
                            else
                            begin
                                res_status_next = 1'b1;
                                state_next      = ST_DONE;
                            end
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_MOD:
            begin
                res_status_next = !cmd_present;
                res_mode_next   = set_write ? tgt_rec.mode : rd_data.mode;
                if (set_write)
                begin
                    wr_en      = 1'b1;
                    wr_addr    = cmd_addr;
                    wr_data    = tgt_rec;
                    blink_next = blink_after;
                    if (timer_start)
                    begin
                        timer_next = 1'b1;
                        slot_next  = '0;
                    end
                    else if (!any_blink && timer_reg)
                    begin
                        timer_next = 1'b0;
                    end
                    pins_next[cmd_pin] = (set_lit == cfg.active_high[cmd_pin]);
                end
                state_next = ST_DONE;
            end
            ST_TICK:
            begin
                // issue the next read while the previous record is updated
                proc_vld_next = issuing;
                if (issuing)
                begin
                    rd_en         = 1'b1;
                    rd_addr       = iss_reg[AW-1:0];
                    iss_next      = iss_reg + 1'b1;
                    proc_idx_next = iss_reg[AW-1:0];
                end
                if (proc_vld_reg && tick_act)
                begin
                    if (tick_pin_ok &&
                        mask_bit(rd_data.mask, SLOT_MAX_W'(prev_slot_reg)) !=
                        mask_bit(rd_data.mask, SLOT_MAX_W'(slot_reg)))
                    begin
                        pins_next[tick_pin] = !pins_reg[tick_pin];
                    end
                    if (!rd_data.rep_forever)
                    begin
                        wr_en   = 1'b1;
                        wr_addr = proc_idx_reg;
                        wr_data = tick_rec;
                        if (tick_rec.mode == MODE_OFF)
                        begin
                            blink_next[proc_idx_reg] = 1'b0;
                            if (tick_pin_ok)
                            begin
                                pins_next[tick_pin] = !cfg.active_high[tick_pin];
                            end
                        end
                    end
                end
                if (proc_vld_reg && !issuing)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            timer_reg    <= 1'b0;
            slot_reg     <= '0;
            blink_reg    <= '0;
            pins_reg     <= '0;
            iss_reg      <= '0;
            proc_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            timer_reg    <= timer_next;
            slot_reg     <= slot_next;
            blink_reg    <= blink_next;
            pins_reg     <= pins_next;
            iss_reg      <= iss_next;
            proc_vld_reg <= proc_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        prev_slot_reg  <= prev_slot_next;
        proc_idx_reg   <= proc_idx_next;
        res_mode_reg   <= res_mode_next;
        res_status_reg <= res_status_next;
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);
    assign res_data  = '{pin_levels:    pins_reg,
                         led_mode_out:  res_mode_reg,
                         status:        res_status_reg,
                         timer_running: timer_reg};

`ifndef SYNTHESIS
    a_blink_needs_timer: assert property (@(posedge clk) disable iff (!rst_n)
        (blink_reg != '0) |-> timer_reg)
        else $error("LED blinking while slot timer is stopped");

    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(slot_reg) < SLOT_COUNT)
        else $error("slot index out of range");

    a_timer_start_slot: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(timer_reg) |-> (slot_reg == '0))
        else $error("slot timer started away from slot zero");

    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(iss_reg) <= LED_COUNT)
        else $error("tick walk ran past the last LED");
`endif

endmodule

### hdl/led_slot_pattern_blinker.sv
`timescale 1ns / 1ps
// Top level of the LED slot pattern blinker: configuration registers, result
// register, sequencer and LED record memory. Uses lspb_pkg, lspb_seq, lspb_led_ram.
//
// Usage:
//   in channel  (in_valid / in_stall / in_data): one command word per item:
//     tick, set off, set on, blink default, blink, toggle or read.
//   out channel (out_valid / out_stall / out_data): exactly one result word
//     per command: pin levels, mode of the addressed LED, status, timer state.
//   cfg channel (cfg_valid / cfg_ready / cfg_index / cfg_data): writes the
//     present mask, polarity mask and default blink mask; always ready.
// Flow: a set or read command is taken, its LED record is read and, if it changes,
//   written back in the next cycle, and the result is then registered in the output
//   register. A tick while the timer runs walks every LED record through the single
//   read port of the record memory. A tick with the timer stopped walks no record.
// Reset: all LEDs off, pins at the unlit level, timer stopped at slot zero.
// Stall: a finished word waits in the output register; the next command is
//   still taken, and its result holds inside until the register frees up.
module led_slot_pattern_blinker #(
    parameter int LED_COUNT = 4,
    parameter int SLOT_COUNT = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  lspb_pkg::cmd_word_t                 in_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output lspb_pkg::res_word_t                 out_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lspb_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [lspb_pkg::CFG_DAT_W-1:0]      cfg_data
);
    import lspb_pkg::*;

    localparam int AW = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;

    cfg_t      cfg_reg;
    logic      out_valid_reg;
    res_word_t out_data_reg;

    logic      res_valid;
    logic      res_ready;
    res_word_t res_data;
    logic      wr_en;
    logic [AW-1:0] wr_addr;
    led_rec_t  wr_data;
    logic      rd_en;
    logic [AW-1:0] rd_addr;
    led_rec_t  rd_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.present      <= 4'hF;
            cfg_reg.active_high  <= 4'hF;
            cfg_reg.default_mask <= 16'h00FF;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_PRESENT:      cfg_reg.present      <= cfg_data[PIN_W-1:0];
                REG_ACTIVE_HIGH:  cfg_reg.active_high  <= cfg_data[PIN_W-1:0];
                REG_DEFAULT_MASK: cfg_reg.default_mask <= cfg_data[MASK_W-1:0];
                default:          cfg_reg.present      <= cfg_reg.present;
            endcase
        end
    end

    // load a new word when the register is empty or its word leaves now
    assign res_ready = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_data_reg <= res_data;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    lspb_seq #(
        .LED_COUNT  (LED_COUNT),
        .SLOT_COUNT (SLOT_COUNT),
        .AW         (AW)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .cfg       (cfg_reg),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data)
    );

    lspb_led_ram #(
        .LED_COUNT (LED_COUNT),
        .AW        (AW)
    ) u_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

endmodule
